@@ hw/rtl/ir2fft_pkg.sv @@
// Shared types and constants for the iterative radix-2 FFT engine.
// Holds request and result codes, register addresses and the twiddle
// table generator; depends on nothing else.
package ir2fft_pkg;

    localparam int WORD_W = 27;
    localparam int TW_W   = 18;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic signed [TW_W-1:0]   twiddle_t;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic RES_BIN  = 1'b0;
    localparam logic RES_DONE = 1'b1;

    localparam logic [2:0] ADDR_SIZE_LOG2 = 3'd0;
    localparam logic [2:0] ADDR_DIRECTION = 3'd4;

    localparam logic [3:0] SIZE_LOG2_RESET = 4'd10;

    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam int TAYLOR_STEPS = 11;

    localparam longint unsigned COS_DIV [TAYLOR_STEPS] =
        '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240,
          64'd306, 64'd380, 64'd462};
    localparam longint unsigned SIN_DIV [TAYLOR_STEPS] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272,
          64'd342, 64'd420, 64'd506};

    function automatic twiddle_t to_q15(longint v);
        longint r;
        r = (v + 64'sd16384) >>> 15;
        if (r > 64'sd32768)
            r = 64'sd32768;
        if (r < -64'sd32768)
            r = -64'sd32768;
        return TW_W'(r);
    endfunction

    // Entry q of a table with h = 2^lg entries: cos and sin of pi*q/h, Q2.15 (18-bit signed).
    function automatic logic [2*TW_W-1:0] tw_entry(int unsigned q, int unsigned lg);
        longint unsigned h;
        longint unsigned qq;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          c;
        longint          s;
        bit              fold;
        h    = 64'd1 << lg;
        fold = (2 * longint'(q)) > h;
        qq   = fold ? h - q : longint'(q);
        x    = (PI_Q30 * qq + (h >> 1)) >> lg;
        x2   = (x * x) >> 30;
        term = 64'd1 << 30;
        c    = longint'(term);
        for (int n = 0; n < TAYLOR_STEPS; n++)
        begin
            term = ((term * x2) >> 30) / COS_DIV[n];
            if (n % 2 == 0)
                c = c - longint'(term);
            else
                c = c + longint'(term);
        end
        term = x;
        s    = longint'(term);
        for (int n = 0; n < TAYLOR_STEPS; n++)
        begin
            term = ((term * x2) >> 30) / SIN_DIV[n];
            if (n % 2 == 0)
                s = s - longint'(term);
            else
                s = s + longint'(term);
        end
        return {to_q15(fold ? -c : c), to_q15(s)};
    endfunction

endpackage

@@ hw/rtl/iterative_radix2_fft_engine.sv @@
// Iterative radix-2 decimation-in-time FFT engine, top level.
// Uses ir2fft_pkg for codes, word types and the twiddle table.
// Holds the point memory, the twiddle ROM and the transform sequencer.
//
// Load and read words go straight to a single-port-write point memory: a load is
// written as it is accepted; a read passes the memory read register and the output
// register, and the next word is taken after that. A start word runs the
// bit-reversal pass (a check and an advance per index, two reads and two writes
// per swapped pair), then (N/2)*log2(N) butterflies (two reads, multiply, round,
// two writes, advance), since every butterfly reads two entries and writes two
// through the one read and one write port; the done word follows. Transform length
// N = 2^size_log2 is clamped to 2..2^MAX_POINTS_LOG2. Every index in use must be
// loaded before start. Results are not scaled by 1/N.
module iterative_radix2_fft_engine #(
    parameter int MAX_POINTS_LOG2 = 10,
    parameter int SAMPLE_WIDTH    = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    // index, sample_re, sample_im, zero pad
    input  logic [((MAX_POINTS_LOG2+2*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
    // req_type
    input  logic [1:0]  s_tuser,
    // stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    // bin_re, bin_im, zero pad
    output logic [55:0] m_tdata,
    // result_kind
    output logic        m_tuser,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ir2fft_pkg::*;

    localparam int AW     = MAX_POINTS_LOG2;
    localparam int DEPTH  = 1 << AW;
    localparam int TW_AW  = (AW > 1) ? AW - 1 : 1;
    localparam int TW_N   = 1 << TW_AW;
    localparam int LW     = 5;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_PCHK  = 9'b000000010,
        ST_RD_A  = 9'b000000100,
        ST_RD_B  = 9'b000001000,
        ST_MUL   = 9'b000010000,
        ST_SUM   = 9'b000100000,
        ST_WR_A  = 9'b001000000,
        ST_WR_B  = 9'b010000000,
        ST_ADV   = 9'b100000000
    } state_t;

    // ---------------- configuration
    logic [3:0] size_log2_reg;
    logic       direction_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_log2_reg <= SIZE_LOG2_RESET;
            direction_reg <= 1'b0;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr == ADDR_SIZE_LOG2)
                size_log2_reg <= pwdata[3:0];
            else if (paddr == ADDR_DIRECTION)
                direction_reg <= pwdata[0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == ADDR_SIZE_LOG2)
            prdata = {28'd0, size_log2_reg};
        else if (paddr == ADDR_DIRECTION)
            prdata = {31'd0, direction_reg};
    end

    logic [LW-1:0] used_l;
    always_comb
    begin
        used_l = LW'(size_log2_reg);
        if (used_l < LW'(1))
            used_l = LW'(1);
        if (used_l > LW'(AW))
            used_l = LW'(AW);
    end

    logic [AW:0]   len_full;
    logic [AW-1:0] len_mask;
    logic [AW-1:0] half_mask;
    assign len_full  = ((AW+1)'(1) << used_l) - (AW+1)'(1);
    assign len_mask  = len_full[AW-1:0];
    assign half_mask = len_mask >> 1;

    // ---------------- input fields
    logic [1:0]              in_kind;
    logic [AW-1:0]           in_index;
    logic [SAMPLE_WIDTH-1:0] in_re;
    logic [SAMPLE_WIDTH-1:0] in_im;

    assign in_kind  = s_tuser;
    assign in_index = s_tdata[AW-1:0] & len_mask;
    assign in_re    = s_tdata[AW +: SAMPLE_WIDTH];
    assign in_im    = s_tdata[AW+SAMPLE_WIDTH +: SAMPLE_WIDTH];

    function automatic word_t sat_sample(logic [SAMPLE_WIDTH-1:0] v);
        logic signed [32:0] x;
        x = 33'(signed'(v));
        if (x > 33'sd67108863)
            return word_t'(27'sd67108863);
        if (x < -33'sd67108864)
            return word_t'(-27'sd67108864);
        return word_t'(x);
    endfunction

    function automatic word_t sat_sum(logic signed [31:0] v);
        if (v > 32'sd67108863)
            return word_t'(27'sd67108863);
        if (v < -32'sd67108864)
            return word_t'(-27'sd67108864);
        return word_t'(v);
    endfunction

    // ---------------- twiddle ROM
    logic [2*TW_W-1:0] tw_rom [TW_N];
    for (genvar g = 0; g < TW_N; g++)
    begin : g_tw
        localparam logic [2*TW_W-1:0] ENTRY = tw_entry(g, TW_AW);
        assign tw_rom[g] = ENTRY;
    end

    // ---------------- sequencer state
    state_t         state_reg;
    logic           perm_reg;
    logic [AW-1:0]  cnt_reg;
    logic [LW-1:0]  stage_reg;
    logic           pend_reg;
    logic           out_valid_reg;
    logic           out_kind_reg;
    word_t          out_re_reg;
    word_t          out_im_reg;

    word_t          a_re_reg, a_im_reg, b_re_reg, b_im_reg;
    logic [2*WORD_W-1:0] rdata_reg;
    logic [2*TW_W-1:0]   tw_reg;
    logic signed [TW_W+WORD_W-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [31:0] y_re_reg, y_im_reg;

    logic out_free;
    logic accept;
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && !pend_reg && out_free;
    assign accept   = s_tvalid && s_tready;

    // butterfly / permutation addresses
    logic [AW-1:0] mid_bit, mid_mask, ia, ib, kk, rev_full, rev;
    logic [AW-1:0] q_full;
    always_comb
    begin
        mid_bit  = AW'(1) << stage_reg;
        mid_mask = mid_bit - AW'(1);
        kk       = cnt_reg & mid_mask;
        q_full   = kk << (LW'(AW - 1) - stage_reg);
        for (int b = 0; b < AW; b++)
            rev_full[b] = cnt_reg[AW-1-b];
        rev = rev_full >> (LW'(AW) - used_l);
        if (perm_reg)
        begin
            ia = cnt_reg;
            ib = rev;
        end
        else
        begin
            ia = (((cnt_reg >> stage_reg) << stage_reg) << 1) | kk;
            ib = ia | mid_bit;
        end
    end

    // ---------------- point memory
    logic [2*WORD_W-1:0] mem [DEPTH];
    logic                we;
    logic [AW-1:0]       waddr, raddr;
    logic [2*WORD_W-1:0] wdata;

    always_comb
    begin
        we    = 1'b0;
        waddr = ia;
        wdata = {b_im_reg, b_re_reg};
        raddr = in_index;
        case (state_reg)
            ST_IDLE:
            begin
                we    = accept && (in_kind == REQ_LOAD);
                waddr = in_index;
                wdata = {sat_sample(in_im), sat_sample(in_re)};
            end
            ST_RD_A: raddr = ia;
            ST_RD_B: raddr = ib;
            ST_WR_A:
            begin
                we    = 1'b1;
                waddr = ia;
                if (perm_reg)
                    wdata = {b_im_reg, b_re_reg};
                else
                    wdata = {sat_sum(32'(a_im_reg) + y_im_reg),
                             sat_sum(32'(a_re_reg) + y_re_reg)};
            end
            ST_WR_B:
            begin
                we    = 1'b1;
                waddr = ib;
                if (perm_reg)
                    wdata = {a_im_reg, a_re_reg};
                else
                    wdata = {sat_sum(32'(a_im_reg) - y_im_reg),
                             sat_sum(32'(a_re_reg) - y_re_reg)};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
        tw_reg    <= tw_rom[q_full[TW_AW-1:0]];
    end

    // ---------------- datapath
    twiddle_t tw_c, tw_s, tw_wi;
    word_t    rd_re, rd_im;
    assign tw_c  = tw_reg[2*TW_W-1:TW_W];
    assign tw_s  = tw_reg[TW_W-1:0];
    assign tw_wi = direction_reg ? -tw_s : tw_s;
    assign rd_re = rdata_reg[WORD_W-1:0];
    assign rd_im = rdata_reg[2*WORD_W-1:WORD_W];

    logic signed [TW_W+WORD_W:0] s_re, s_im;
    assign s_re = (TW_W+WORD_W+1)'(p_rr_reg) - (TW_W+WORD_W+1)'(p_ii_reg)
                  + (TW_W+WORD_W+1)'(16384);
    assign s_im = (TW_W+WORD_W+1)'(p_ri_reg) + (TW_W+WORD_W+1)'(p_ir_reg)
                  + (TW_W+WORD_W+1)'(16384);

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_RD_B:
            begin
                a_re_reg <= rd_re;
                a_im_reg <= rd_im;
            end
            ST_MUL:
            begin
                b_re_reg <= rd_re;
                b_im_reg <= rd_im;
                p_rr_reg <= tw_c  * rd_re;
                p_ii_reg <= tw_wi * rd_im;
                p_ri_reg <= tw_c  * rd_im;
                p_ir_reg <= tw_wi * rd_re;
            end
            ST_SUM:
            begin
                y_re_reg <= 32'(s_re >>> 15);
                y_im_reg <= 32'(s_im >>> 15);
            end
            default: ;
        endcase
    end

    // ---------------- control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            perm_reg      <= 1'b0;
            cnt_reg       <= '0;
            stage_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= RES_BIN;
            out_re_reg    <= '0;
            out_im_reg    <= '0;
        end
        else
        begin
            if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            pend_reg <= 1'b0;
            if (pend_reg)
            begin
                out_valid_reg <= 1'b1;
                out_kind_reg  <= RES_BIN;
                out_re_reg    <= rd_re;
                out_im_reg    <= rd_im;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (in_kind == REQ_READ))
                        pend_reg <= 1'b1;
                    if (accept && (in_kind == REQ_START))
                    begin
                        perm_reg  <= 1'b1;
                        cnt_reg   <= '0;
                        stage_reg <= '0;
                        state_reg <= ST_PCHK;
                    end
                end
                ST_PCHK:   state_reg <= (cnt_reg < rev) ? ST_RD_A : ST_ADV;
                ST_RD_A:   state_reg <= ST_RD_B;
                ST_RD_B:   state_reg <= ST_MUL;
                ST_MUL:    state_reg <= perm_reg ? ST_WR_A : ST_SUM;
                ST_SUM:    state_reg <= ST_WR_A;
                ST_WR_A:   state_reg <= ST_WR_B;
                ST_WR_B:   state_reg <= ST_ADV;
                ST_ADV:
                begin
                    if (perm_reg)
                    begin
                        if (cnt_reg == len_mask)
                        begin
                            perm_reg  <= 1'b0;
                            cnt_reg   <= '0;
                            state_reg <= ST_RD_A;
                        end
                        else
                        begin
                            cnt_reg   <= cnt_reg + AW'(1);
                            state_reg <= ST_PCHK;
                        end
                    end
                    else if (cnt_reg == half_mask)
                    begin
                        cnt_reg <= '0;
                        if (stage_reg == used_l - LW'(1))
                        begin
                            // last stage done: report once the output is free
                            if (out_free && !pend_reg)
                            begin
                                out_valid_reg <= 1'b1;
                                out_kind_reg  <= RES_DONE;
                                out_re_reg    <= '0;
                                out_im_reg    <= '0;
                                state_reg     <= ST_IDLE;
                            end
                            else
                                cnt_reg <= half_mask;
                        end
                        else
                        begin
                            stage_reg <= stage_reg + LW'(1);
                            state_reg <= ST_RD_A;
                        end
                    end
                    else
                    begin
                        cnt_reg   <= cnt_reg + AW'(1);
                        state_reg <= ST_RD_A;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {2'b00, out_im_reg, out_re_reg};

endmodule
